// File: design/wav_header_parser_assert.svh
`ifndef WAV_HEADER_PARSER_ASSERT_SVH
`define WAV_HEADER_PARSER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define WAVHP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define WAVHP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/wavhp_pkg.sv
package wavhp_pkg;

    typedef enum logic [3:0] {
        ST_VALID = 4'd0,
        ST_RIFF  = 4'd1,
        ST_WAVE  = 4'd2,
        ST_FMT   = 4'd3,
        ST_PCM   = 4'd4,
        ST_BITS  = 4'd5,
        ST_EXTRA = 4'd6,
        ST_FACT  = 4'd7,
        ST_DATA  = 4'd8
    } t_status;

    typedef logic [5:0] t_pos;

    typedef struct packed {
        logic [31:0] riff_size;
        logic [31:0] fmt_size;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
    } t_fields;

    typedef struct packed {
        t_status     status;
        t_fields     fields;
        logic [31:0] data_size;
        logic [31:0] data_offset;
    } t_result;

    // Tags, byte 0 of the tag in bits [7:0]
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam t_pos TAIL_PLAIN = 6'd36;
    localparam t_pos TAIL_EXTRA = 6'd46;
    localparam t_pos POS_MAX    = 6'd54;
    localparam t_pos FACT_START = 6'd38;

    localparam logic [31:0] OFFSET_PLAIN = 32'd44;
    localparam logic [31:0] OFFSET_EXTRA = 32'd54;
    localparam logic [31:0] FMT_SIZE_PCM = 32'd16;
    localparam logic [15:0] FORMAT_PCM   = 16'd1;
    localparam logic [15:0] BITS_8       = 16'd8;
    localparam logic [15:0] BITS_16      = 16'd16;

    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
        return tag[{idx, 3'b000} +: 8];
    endfunction

endpackage

// File: design/wav_header_parser.sv
// WAV header parser: feed the file one byte per request, with i_first_byte set on byte
// zero; it checks the RIFF/WAVE/fmt tags, PCM format and 8 or 16 bits per sample, an
// optional zero extra-size field plus fact chunk (whose data it skips), then the data
// tag and size, and gives at most one result per file, at the first failing byte or
// after the last byte of the data size; bytes after that are dropped until the next
// first byte. A byte is taken every cycle while o_in_stall is low: it passes an input
// register, combinational parse logic, and a result register, which loads when the
// parse stage takes the byte from the input register. While a result is held under
// i_out_stall, the parse stage does not advance, so o_in_stall rises as soon as a byte
// waits in the input register, whether or not that byte would give a result.
module wav_header_parser
    import wavhp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_header_byte,
    input  logic        i_first_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_status,
    output logic [31:0] o_riff_size,
    output logic [31:0] o_fmt_size,
    output logic [15:0] o_format_tag,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_sample_rate,
    output logic [31:0] o_byte_rate,
    output logic [15:0] o_block_align,
    output logic [15:0] o_sample_bits,
    output logic [31:0] o_data_size,
    output logic [31:0] o_data_offset
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_first;
    logic       out_free;
    logic       fire;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    wavhp_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_header_byte (i_header_byte),
        .i_first_byte  (i_first_byte),
        .i_advance     (out_free),
        .o_valid       (in_valid),
        .o_header_byte (in_byte),
        .o_first_byte  (in_first)
    );

    assign fire = in_valid && out_free;

    wavhp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_header_byte (in_byte),
        .i_first_byte  (in_first),
        .o_res_valid   (res_valid),
        .o_result      (res)
    );

    wavhp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (res),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_res)
    );

    assign o_status        = out_res.status;
    assign o_riff_size     = out_res.fields.riff_size;
    assign o_fmt_size      = out_res.fields.fmt_size;
    assign o_format_tag    = out_res.fields.format_tag;
    assign o_channel_count = out_res.fields.channel_count;
    assign o_sample_rate   = out_res.fields.sample_rate;
    assign o_byte_rate     = out_res.fields.byte_rate;
    assign o_block_align   = out_res.fields.block_align;
    assign o_sample_bits   = out_res.fields.sample_bits;
    assign o_data_size     = out_res.data_size;
    assign o_data_offset   = out_res.data_offset;

endmodule

// File: design/wavhp_in_reg.sv
module wavhp_in_reg
    import wavhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_header_byte,
    input  logic       i_first_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_header_byte,
    output logic       o_first_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       r_first;
    logic       accept;

    // Hold the request while the parse stage cannot advance
    assign o_stall = r_valid && !i_advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte  <= i_header_byte;
            r_first <= i_first_byte;
        end
    end

    assign o_valid       = r_valid;
    assign o_header_byte = r_byte;
    assign o_first_byte  = r_first;

endmodule

// File: design/wavhp_parse.sv
`include "wav_header_parser_assert.svh"

module wavhp_parse
    import wavhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_header_byte,
    input  logic       i_first_byte,
    output logic       o_res_valid,
    output t_result    o_result
);

    t_pos        r_pos, n_pos, b_pos;
    logic [31:0] r_shift, n_shift, b_shift;
    logic [31:0] r_skip, n_skip, b_skip;
    logic        r_has_extra, n_has_extra, b_has_extra;
    logic        r_done;
    t_fields     r_fields, n_fields, b_fields;
    logic [31:0] r_fact_offset, n_fact_offset, b_fact_offset;

    logic        b_active;
    logic        skip_now;
    logic [31:0] w;
    t_pos        tail;
    t_pos        d;
    t_pos        fact_idx;
    logic [32:0] offset_sum;
    logic        has_result;
    t_status     status;
    logic [31:0] data_size;
    logic [31:0] data_offset;

    // Base state: a first byte starts from a cleared file
    always_comb begin
        if (i_first_byte) begin
            b_pos         = '0;
            b_shift       = '0;
            b_skip        = '0;
            b_has_extra   = 1'b0;
            b_fields      = '0;
            b_fact_offset = '0;
            b_active      = 1'b1;
        end else begin
            b_pos         = r_pos;
            b_shift       = r_shift;
            b_skip        = r_skip;
            b_has_extra   = r_has_extra;
            b_fields      = r_fields;
            b_fact_offset = r_fact_offset;
            b_active      = !r_done;
        end
    end

    assign skip_now   = b_has_extra && (b_pos == TAIL_EXTRA) && (b_skip != '0);
    assign w          = {i_header_byte, b_shift[31:8]};
    assign tail       = b_has_extra ? TAIL_EXTRA : TAIL_PLAIN;
    assign d          = b_pos - tail;
    assign fact_idx   = b_pos - FACT_START;
    assign offset_sum = {1'b0, w} + {1'b0, OFFSET_EXTRA};

    always_comb begin
        n_pos         = b_pos;
        n_shift       = b_shift;
        n_skip        = b_skip;
        n_has_extra   = b_has_extra;
        n_fields      = b_fields;
        n_fact_offset = b_fact_offset;
        has_result    = 1'b0;
        status        = ST_VALID;
        data_size     = '0;
        data_offset   = '0;

        if (skip_now) begin
            n_skip = b_skip - 32'd1;
        end else begin
            n_shift = w;
            n_pos   = b_pos + 6'd1;
            if (b_pos < 6'd4) begin
                if (i_header_byte != tag_byte(TAG_RIFF, b_pos[1:0])) begin
                    has_result = 1'b1;
                    status     = ST_RIFF;
                end
            end else if (b_pos < 6'd8) begin
                if (b_pos == 6'd7) begin
                    n_fields.riff_size = w;
                end
            end else if (b_pos < 6'd12) begin
                if (i_header_byte != tag_byte(TAG_WAVE, b_pos[1:0])) begin
                    has_result = 1'b1;
                    status     = ST_WAVE;
                end
            end else if (b_pos < 6'd16) begin
                if (i_header_byte != tag_byte(TAG_FMT, b_pos[1:0])) begin
                    has_result = 1'b1;
                    status     = ST_FMT;
                end
            end else if (b_pos < TAIL_PLAIN) begin
                case (b_pos)
                    6'd19: begin
                        n_fields.fmt_size = w;
                        n_has_extra       = (w != FMT_SIZE_PCM);
                    end
                    6'd21: n_fields.format_tag    = w[31:16];
                    6'd23: n_fields.channel_count = w[31:16];
                    6'd27: n_fields.sample_rate   = w;
                    6'd31: n_fields.byte_rate     = w;
                    6'd33: n_fields.block_align   = w[31:16];
                    6'd35: begin
                        n_fields.sample_bits = w[31:16];
                        if (b_fields.format_tag != FORMAT_PCM) begin
                            has_result = 1'b1;
                            status     = ST_PCM;
                        end else if (!(w[31:16] inside {BITS_8, BITS_16})) begin
                            has_result = 1'b1;
                            status     = ST_BITS;
                        end
                    end
                    default: ;
                endcase
            end else if (b_pos < tail) begin
                if (b_pos < FACT_START) begin
                    if (i_header_byte != 8'h00) begin
                        has_result = 1'b1;
                        status     = ST_EXTRA;
                    end
                end else if (b_pos < 6'd42) begin
                    if (i_header_byte != tag_byte(TAG_FACT, fact_idx[1:0])) begin
                        has_result = 1'b1;
                        status     = ST_FACT;
                    end
                end else if (b_pos == 6'd45) begin
                    n_skip        = w;
                    // Precompute the saturated audio offset past the fact data
                    n_fact_offset = offset_sum[32] ? '1 : offset_sum[31:0];
                end
            end else begin
                if (d < 6'd4) begin
                    if (i_header_byte != tag_byte(TAG_DATA, d[1:0])) begin
                        has_result = 1'b1;
                        status     = ST_DATA;
                    end
                end else if (d == 6'd7) begin
                    has_result  = 1'b1;
                    status      = ST_VALID;
                    data_size   = w;
                    data_offset = b_has_extra ? b_fact_offset : OFFSET_PLAIN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_shift     <= '0;
            r_skip      <= '0;
            r_has_extra <= 1'b0;
            r_done      <= 1'b1;
        end else if (i_fire && b_active) begin
            r_pos       <= n_pos;
            r_shift     <= n_shift;
            r_skip      <= n_skip;
            r_has_extra <= n_has_extra;
            r_done      <= has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fields      <= '0;
            r_fact_offset <= '0;
        end else if (i_fire && b_active) begin
            r_fields      <= n_fields;
            r_fact_offset <= n_fact_offset;
        end
    end

    assign o_res_valid          = i_fire && b_active && has_result;
    assign o_result.status      = status;
    assign o_result.fields      = n_fields;
    assign o_result.data_size   = data_size;
    assign o_result.data_offset = data_offset;

    `WAVHP_ASSERT_NEXT(a_done_after_result, i_clk, i_rst_n, o_res_valid, r_done, "parse not closed after result")
    `WAVHP_ASSERT_NOW(a_pos_bound, i_clk, i_rst_n, !r_done, r_pos <= POS_MAX, "header position out of range")
    `WAVHP_ASSERT_NOW(a_skip_needs_extra, i_clk, i_rst_n, r_skip != '0, r_has_extra, "fact skip without extended fmt")
    `WAVHP_ASSERT_NEXT(a_skip_holds_pos, i_clk, i_rst_n, i_fire && skip_now && !i_first_byte && !r_done, r_pos == TAIL_EXTRA, "position moved during fact skip")

endmodule

// File: design/wavhp_out_reg.sv
module wavhp_out_reg
    import wavhp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Free when empty or when the held result leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
